// ===== sv/vct_pkg.sv =====
package vct_pkg;

  localparam int LETTERS = 67;
  localparam int ENTRIES = 134;

  typedef enum logic [1:0] {
    SET_UNICODE = 2'd0,
    SET_TCVN3   = 2'd1,
    SET_VNI     = 2'd2
  } set_e;

  typedef enum logic [1:0] {
    CFG_SOURCE_SET = 2'd0,
    CFG_TARGET_SET = 2'd1
  } cfg_idx_e;

  // decoded characters handed to the encoder
  typedef struct packed {
    logic        pass;
    logic        two;
    logic [15:0] c0;
    logic [15:0] c1;
  } dec_t;

  // encoded units of one input item
  typedef struct packed {
    logic        two;
    logic [15:0] u0;
    logic [15:0] u1;
  } enc_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] chr;
  } pair_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
  } find_t;

  localparam logic [15:0] UNI_TAB [ENTRIES] = '{
    16'h00E0, 16'h00E1, 16'h1EA3, 16'h00E3, 16'h1EA1,
    16'h0103, 16'h1EB1, 16'h1EAF, 16'h1EB3, 16'h1EB5, 16'h1EB7,
    16'h00E2, 16'h1EA7, 16'h1EA5, 16'h1EA9, 16'h1EAB, 16'h1EAD,
    16'h00E8, 16'h00E9, 16'h1EBB, 16'h1EBD, 16'h1EB9,
    16'h00EA, 16'h1EC1, 16'h1EBF, 16'h1EC3, 16'h1EC5, 16'h1EC7,
    16'h00EC, 16'h00ED, 16'h1EC9, 16'h0129, 16'h1ECB,
    16'h00F2, 16'h00F3, 16'h1ECF, 16'h00F5, 16'h1ECD,
    16'h00F4, 16'h1ED3, 16'h1ED1, 16'h1ED5, 16'h1ED7, 16'h1ED9,
    16'h01A1, 16'h1EDD, 16'h1EDB, 16'h1EDF, 16'h1EE1, 16'h1EE3,
    16'h00F9, 16'h00FA, 16'h1EE7, 16'h0169, 16'h1EE5,
    16'h01B0, 16'h1EEB, 16'h1EE9, 16'h1EED, 16'h1EEF, 16'h1EF1,
    16'h1EF3, 16'h00FD, 16'h1EF7, 16'h1EF9, 16'h1EF5,
    16'h0111,
    16'h00C0, 16'h00C1, 16'h1EA2, 16'h00C3, 16'h1EA0,
    16'h0102, 16'h1EB0, 16'h1EAE, 16'h1EB2, 16'h1EB4, 16'h1EB6,
    16'h00C2, 16'h1EA6, 16'h1EA4, 16'h1EA8, 16'h1EAA, 16'h1EAC,
    16'h00C8, 16'h00C9, 16'h1EBA, 16'h1EBC, 16'h1EB8,
    16'h00CA, 16'h1EC0, 16'h1EBE, 16'h1EC2, 16'h1EC4, 16'h1EC6,
    16'h00CC, 16'h00CD, 16'h1EC8, 16'h0128, 16'h1ECA,
    16'h00D2, 16'h00D3, 16'h1ECE, 16'h00D5, 16'h1ECC,
    16'h00D4, 16'h1ED2, 16'h1ED0, 16'h1ED4, 16'h1ED6, 16'h1ED8,
    16'h01A0, 16'h1EDC, 16'h1EDA, 16'h1EDE, 16'h1EE0, 16'h1EE2,
    16'h00D9, 16'h00DA, 16'h1EE6, 16'h0168, 16'h1EE4,
    16'h01AF, 16'h1EEA, 16'h1EE8, 16'h1EEC, 16'h1EEE, 16'h1EF0,
    16'h1EF2, 16'h00DD, 16'h1EF6, 16'h1EF8, 16'h1EF4,
    16'h0110
  };

  localparam logic [7:0] TCVN_TAB [ENTRIES] = '{
    8'hB5, 8'hB8, 8'hB6, 8'hB7, 8'hB9, 8'hA8, 8'hBB, 8'hBE, 8'hBC, 8'hBD, 8'hC6,
    8'hA9, 8'hC7, 8'hCA, 8'hC8, 8'hC9, 8'hCB, 8'hCC, 8'hCE, 8'hCD, 8'hD0, 8'hCF,
    8'hAA, 8'hD1, 8'hD4, 8'hD2, 8'hD3, 8'hD5, 8'hD6, 8'hD8, 8'hD7, 8'hD9, 8'hDA,
    8'hDB, 8'hDD, 8'hDC, 8'hDE, 8'hDF, 8'hAB, 8'hE0, 8'hE3, 8'hE1, 8'hE2, 8'hE4,
    8'hAC, 8'hE5, 8'hE8, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEC, 8'hEB, 8'hED, 8'hEE,
    8'hAF, 8'hEF, 8'hF2, 8'hF0, 8'hF1, 8'hF3, 8'hF4, 8'hF6, 8'hF5, 8'hF8, 8'hF7,
    8'hAE,
    8'h95, 8'h98, 8'h96, 8'h97, 8'h99, 8'h88, 8'h9B, 8'h9E, 8'h9C, 8'h9D, 8'hA6,
    8'h89, 8'hA7, 8'hAA, 8'hA8, 8'hA9, 8'hAB, 8'hAC, 8'hAE, 8'hAD, 8'hB0, 8'hAF,
    8'h8A, 8'hB1, 8'hB4, 8'hB2, 8'hB3, 8'hB5, 8'hB6, 8'hB8, 8'hB7, 8'hB9, 8'hBA,
    8'hBB, 8'hBD, 8'hBC, 8'hBE, 8'hBF, 8'h8B, 8'hC0, 8'hC3, 8'hC1, 8'hC2, 8'hC4,
    8'h8C, 8'hC5, 8'hC8, 8'hC6, 8'hC7, 8'hC9, 8'hCA, 8'hCC, 8'hCB, 8'hCD, 8'hCE,
    8'h8F, 8'hCF, 8'hD2, 8'hD0, 8'hD1, 8'hD3, 8'hD4, 8'hD6, 8'hD5, 8'hD8, 8'hD7,
    8'h8E
  };

  localparam logic [7:0] VNI_MARK_LO [LETTERS] = '{
    8'hF8, 8'hF9, 8'hF6, 8'hF5, 8'hFA, 8'hE5, 8'hEB, 8'hE9, 8'hEC, 8'hEA, 8'hED,
    8'hE2, 8'hFB, 8'hFE, 8'hFC, 8'hFD, 8'hFF,
    8'hF8, 8'hF9, 8'hF6, 8'hF5, 8'hFA, 8'hE2, 8'hFB, 8'hFE, 8'hFC, 8'hFD, 8'hFF,
    8'hF8, 8'hF9, 8'hF6, 8'hF5, 8'hFA,
    8'hF8, 8'hF9, 8'hF6, 8'hF5, 8'hFA, 8'hE2, 8'hFB, 8'hFE, 8'hFC, 8'hFD, 8'hFF,
    8'hE1, 8'hEE, 8'hF4, 8'hF1, 8'hEF, 8'hF7,
    8'hF8, 8'hF9, 8'hF6, 8'hF5, 8'hFA, 8'hE1, 8'hEE, 8'hF4, 8'hF1, 8'hEF, 8'hF7,
    8'hF8, 8'hF9, 8'hF6, 8'hF5, 8'hFA,
    8'hF0
  };

  // values 3 means nothing and reads as unicode
  function automatic set_e norm_set(input logic [1:0] s);
    set_e r;
    case (s)
      SET_TCVN3: r = SET_TCVN3;
      SET_VNI:   r = SET_VNI;
      default:   r = SET_UNICODE;
    endcase
    return r;
  endfunction

  // base letter of a vni pair, uppercase half sits 0x20 lower
  function automatic logic [7:0] vni_base(input int i);
    int         k;
    logic [7:0] b;
    k = (i < LETTERS) ? i : i - LETTERS;
    if (k < 17)      b = 8'h61;
    else if (k < 28) b = 8'h65;
    else if (k < 33) b = 8'h69;
    else if (k < 50) b = 8'h6F;
    else if (k < 61) b = 8'h75;
    else if (k < 66) b = 8'h79;
    else             b = 8'h64;
    return (i < LETTERS) ? b : b - 8'h20;
  endfunction

  function automatic logic [7:0] vni_mark(input int i);
    int         k;
    logic [7:0] m;
    k = (i < LETTERS) ? i : i - LETTERS;
    m = VNI_MARK_LO[k];
    return (i < LETTERS) ? m : m - 8'h20;
  endfunction

  // later entry wins on duplicate bytes
  function automatic logic [15:0] tcvn_decode(input logic [15:0] u);
    logic [15:0] r;
    r = u;
    for (int i = 0; i < ENTRIES; i++) begin
      if (u[15:8] == 8'h00 && TCVN_TAB[i] == u[7:0]) r = UNI_TAB[i];
    end
    return r;
  endfunction

  function automatic pair_t vni_pair(input logic [15:0] b, input logic [15:0] m);
    pair_t r;
    r.hit = 1'b0;
    r.chr = 16'h0000;
    for (int i = 0; i < ENTRIES; i++) begin
      if (b == {8'h00, vni_base(i)} && m == {8'h00, vni_mark(i)}) begin
        r.hit = 1'b1;
        r.chr = UNI_TAB[i];
      end
    end
    return r;
  endfunction

  // first match; unicode entries are distinct
  function automatic find_t uni_find(input logic [15:0] c);
    find_t r;
    r.hit = 1'b0;
    r.idx = 8'h00;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (UNI_TAB[i] == c) begin
        r.hit = 1'b1;
        r.idx = 8'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/vct_encoder.sv =====
module vct_encoder (
  input  vct_pkg::set_e dst_i,
  input  vct_pkg::dec_t dec_i,
  output vct_pkg::enc_t enc_o
);

  vct_pkg::find_t f0;
  vct_pkg::find_t f1;

  assign f0 = vct_pkg::uni_find(dec_i.c0);
  assign f1 = vct_pkg::uni_find(dec_i.c1);

  always_comb begin
    enc_o.two = 1'b0;
    enc_o.u0  = dec_i.c0;
    enc_o.u1  = dec_i.c1;
    if (!dec_i.pass) begin
      if (dst_i == vct_pkg::SET_VNI && f0.hit) begin
        // base then mark
        enc_o.two = 1'b1;
        enc_o.u0  = {8'h00, vct_pkg::vni_base(int'(f0.idx))};
        enc_o.u1  = {8'h00, vct_pkg::vni_mark(int'(f0.idx))};
      end else begin
        if (dst_i == vct_pkg::SET_TCVN3 && f0.hit) begin
          enc_o.u0 = {8'h00, vct_pkg::TCVN_TAB[f0.idx]};
        end
        enc_o.two = dec_i.two;
        if (dst_i == vct_pkg::SET_TCVN3 && f1.hit) begin
          enc_o.u1 = {8'h00, vct_pkg::TCVN_TAB[f1.idx]};
        end
      end
    end
  end

endmodule

// ===== sv/vietnamese_charset_transcoder.sv =====
// vietnamese text transcoder between unicode, tcvn3 and vni windows. each
// beat carries one 16-bit code unit; the unit is decoded to unicode in the
// decode stage and encoded into the target set in the encode stage, then
// held in an output register that plays out one or two result beats.
// the decode stage register and the output register lie between an input
// beat and its first result. an item yields two beats for unicode or tcvn3
// to vni or a vni flush at end of text, else one; the output register hands
// out one unit per cycle unless stalled. with a vni source a lone unit is
// held until the next beat shows whether it forms a base+mark pair, so such
// a beat may yield no result; end of text flushes the held unit. program
// source_set and target_set only while the block is idle; a write drops any
// held unit.
module vietnamese_charset_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] in_unit_i,
  input  logic        in_end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_unit_o,
  output logic        run_last_o,
  output logic        out_end_of_text_o
);

  // configuration
  logic [1:0] source_q;
  logic [1:0] target_q;
  vct_pkg::set_e src;
  vct_pkg::set_e dst;

  // vni hold
  logic        held_valid_q, held_valid_d;
  logic [15:0] held_unit_q, held_unit_d;

  // decode stage register
  logic          s1_valid_q;
  logic          s1_end_q;
  vct_pkg::dec_t s1_q;
  vct_pkg::dec_t dec_d;
  logic          dec_any;

  // output register
  logic        ob_valid_q;
  logic        ob_idx_q;
  logic        ob_two_q;
  logic        ob_end_q;
  logic [15:0] ob_u0_q;
  logic [15:0] ob_u1_q;

  vct_pkg::enc_t enc;
  vct_pkg::pair_t pair;

  logic in_acc, out_acc, ob_last, ob_free, s1_adv;

  assign src = vct_pkg::norm_set(source_q);
  assign dst = vct_pkg::norm_set(target_q);

  // handshake
  assign ob_last    = (ob_idx_q == ob_two_q);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign ob_free    = !ob_valid_q || (out_acc && ob_last);
  assign s1_adv     = s1_valid_q && ob_free;
  assign in_stall_o = s1_valid_q && !ob_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= vct_pkg::SET_UNICODE;
      target_q <= vct_pkg::SET_UNICODE;
    end else if (cfg_we_i) begin
      if (cfg_index_i == vct_pkg::CFG_SOURCE_SET) source_q <= cfg_wdata_i;
      if (cfg_index_i == vct_pkg::CFG_TARGET_SET) target_q <= cfg_wdata_i;
    end
  end

  // decode: one or two unicode characters, or none while a vni unit waits
  assign pair = vct_pkg::vni_pair(held_unit_q, in_unit_i);

  always_comb begin
    held_valid_d = held_valid_q;
    held_unit_d  = held_unit_q;
    dec_d.pass   = (src == dst);
    dec_d.two    = 1'b0;
    dec_d.c0     = in_unit_i;
    dec_d.c1     = in_unit_i;
    dec_any      = 1'b1;
    if (src != dst && src == vct_pkg::SET_VNI) begin
      if (held_valid_q) begin
        if (pair.hit) begin
          held_valid_d = 1'b0;
          dec_d.c0     = pair.chr;
        end else begin
          dec_d.c0    = held_unit_q;
          held_unit_d = in_unit_i;
        end
      end else begin
        held_unit_d  = in_unit_i;
        held_valid_d = 1'b1;
        dec_any      = 1'b0;
      end
      // end of text flushes the held unit, which is always this beat's unit
      if (in_end_of_text_i && held_valid_d) begin
        held_valid_d = 1'b0;
        if (dec_any) begin
          dec_d.two = 1'b1;
        end else begin
          dec_d.c0 = in_unit_i;
          dec_any  = 1'b1;
        end
      end
    end else if (src == vct_pkg::SET_TCVN3 && dst != vct_pkg::SET_TCVN3) begin
      dec_d.c0 = vct_pkg::tcvn_decode(in_unit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else if (cfg_we_i && (cfg_index_i == vct_pkg::CFG_SOURCE_SET ||
                              cfg_index_i == vct_pkg::CFG_TARGET_SET)) begin
      held_valid_q <= 1'b0;
    end else if (in_acc) begin
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) held_unit_q <= held_unit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= dec_any;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q     <= dec_d;
      s1_end_q <= in_end_of_text_i;
    end
  end

  // encode into the target set
  vct_encoder u_enc (
    .dst_i (dst),
    .dec_i (s1_q),
    .enc_o (enc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      ob_idx_q   <= 1'b0;
    end else if (s1_adv) begin
      ob_valid_q <= 1'b1;
      ob_idx_q   <= 1'b0;
    end else if (out_acc) begin
      if (ob_last) ob_valid_q <= 1'b0;
      else         ob_idx_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ob_two_q <= enc.two;
      ob_u0_q  <= enc.u0;
      ob_u1_q  <= enc.u1;
      ob_end_q <= s1_end_q;
    end
  end

  assign out_valid_o       = ob_valid_q;
  assign out_unit_o        = ob_idx_q ? ob_u1_q : ob_u0_q;
  assign run_last_o        = ob_last;
  assign out_end_of_text_o = ob_last && ob_end_q;

endmodule

// ===== sv/vct_checker.sv =====
module vct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] out_unit_o,
  input logic        run_last_o,
  input logic        out_end_of_text_o
);

  // end of text only on the last beat of a run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_of_text_o |-> run_last_o)
    else $error("end of text on a beat that is not run last");

  // an empty output side never holds off the input
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // second unit of a run follows the first
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("run cut short");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("valid dropped under stall");

  a_hold_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_unit_o))
    else $error("unit changed under stall");

endmodule

bind vietnamese_charset_transcoder vct_checker u_vct_checker (.*);

// ===== dv/tb_vietnamese_charset_transcoder.sv =====
`timescale 1ns / 1ps

module tb_vietnamese_charset_transcoder;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] in_unit_i;
  logic        in_end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] out_unit_o;
  logic        run_last_o;
  logic        out_end_of_text_o;

  vietnamese_charset_transcoder uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_unit_i         (in_unit_i),
    .in_end_of_text_i  (in_end_of_text_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_unit_o        (out_unit_o),
    .run_last_o        (run_last_o),
    .out_end_of_text_o (out_end_of_text_o)
  );

  // one expected output beat
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        eot;
  } beat_t;

  beat_t exp_beats[$];

  // transcoder model state
  logic [1:0]  src_reg;
  logic [1:0]  dst_reg;
  logic [15:0] hold_unit;
  logic        hold_valid;

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // model lookup tables, kept independent of the package functions
  // ---------------------------------------------------------------------------

  // lowercase base letter of table entry k (k < 67)
  function automatic logic [7:0] base_letter(input int k);
    string s;
    s = "aaaaaaaaaaaaaaaaaeeeeeeeeeeeiiiiiooooooooooooooooouuuuuuuuuuuyyyyyd";
    return s[k];
  endfunction

  function automatic logic [15:0] vni_base_of(input int i);
    logic [7:0] b;
    b = base_letter(i < vct_pkg::LETTERS ? i : i - vct_pkg::LETTERS);
    return {8'h00, (i < vct_pkg::LETTERS) ? b : b - 8'h20};
  endfunction

  function automatic logic [15:0] vni_mark_of(input int i);
    logic [7:0] m;
    m = vct_pkg::VNI_MARK_LO[i < vct_pkg::LETTERS ? i : i - vct_pkg::LETTERS];
    return {8'h00, (i < vct_pkg::LETTERS) ? m : m - 8'h20};
  endfunction

  function automatic vct_pkg::set_e set_of(input logic [1:0] s);
    if (s == vct_pkg::SET_TCVN3) return vct_pkg::SET_TCVN3;
    if (s == vct_pkg::SET_VNI) return vct_pkg::SET_VNI;
    return vct_pkg::SET_UNICODE;
  endfunction

  function automatic logic [15:0] tcvn_to_uni(input logic [15:0] u);
    logic [15:0] r;
    r = u;
    // scan all entries so the later (uppercase) one wins on duplicates
    for (int i = 0; i < vct_pkg::ENTRIES; i++)
      if ({8'h00, vct_pkg::TCVN_TAB[i]} == u) r = vct_pkg::UNI_TAB[i];
    return r;
  endfunction

  // encode one unicode character, push its beats
  task automatic push_encoded(input logic [15:0] c, input vct_pkg::set_e dst);
    beat_t b;
    b = '0;
    if (dst != vct_pkg::SET_UNICODE) begin
      for (int i = 0; i < vct_pkg::ENTRIES; i++) begin
        if (vct_pkg::UNI_TAB[i] == c) begin
          if (dst == vct_pkg::SET_TCVN3) begin
            b.unit = {8'h00, vct_pkg::TCVN_TAB[i]};
            exp_beats.push_back(b);
          end else begin
            b.unit = vni_base_of(i);
            exp_beats.push_back(b);
            b.unit = vni_mark_of(i);
            exp_beats.push_back(b);
          end
          return;
        end
      end
    end
    b.unit = c;
    exp_beats.push_back(b);
  endtask

  // predict the beats of one accepted input
  task automatic predict_transcode(input logic [15:0] u, input logic eot);
    vct_pkg::set_e src;
    vct_pkg::set_e dst;
    int            n0;
    logic          hit;
    logic [15:0]   chr;
    beat_t         b;
    src = set_of(src_reg);
    dst = set_of(dst_reg);
    n0  = exp_beats.size();
    if (src == dst) begin
      b = '0;
      b.unit = u;
      exp_beats.push_back(b);
    end else if (src == vct_pkg::SET_VNI) begin
      if (hold_valid) begin
        hit = 1'b0;
        chr = '0;
        for (int i = 0; i < vct_pkg::ENTRIES; i++)
          if (vni_base_of(i) == hold_unit && vni_mark_of(i) == u) begin
            hit = 1'b1;
            chr = vct_pkg::UNI_TAB[i];
          end
        if (hit) begin
          hold_valid = 1'b0;
          push_encoded(chr, dst);
        end else begin
          push_encoded(hold_unit, dst);
          hold_unit = u;
        end
      end else begin
        hold_unit  = u;
        hold_valid = 1'b1;
      end
      // end of text flushes the held unit
      if (eot && hold_valid) begin
        hold_valid = 1'b0;
        push_encoded(hold_unit, dst);
      end
    end else begin
      push_encoded((src == vct_pkg::SET_TCVN3) ? tcvn_to_uni(u) : u, dst);
    end
    if (exp_beats.size() > n0) begin
      b = exp_beats[$];
      b.last = 1'b1;
      b.eot  = eot;
      exp_beats[$] = b;
    end
  endtask

  // ---------------------------------------------------------------------------
  // output checker and receiver stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: unit=%h last=%b eot=%b",
                   out_unit_o, run_last_o, out_end_of_text_o);
      end else begin
        want = exp_beats.pop_front();
        if (want.unit !== out_unit_o || want.last !== run_last_o ||
            want.eot !== out_end_of_text_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp unit=%h last=%b eot=%b, got unit=%h last=%b eot=%b",
                     want.unit, want.last, want.eot,
                     out_unit_o, run_last_o, out_end_of_text_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // send one beat, honoring the idle ratio; predicts on acceptance
  // valid stays up after acceptance until the next beat or an idle cycle
  task automatic send_unit(input logic [15:0] u, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_unit_i        <= u;
    in_end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transcode(u, eot);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk_i);
    // a held vni unit may still be in flight with nothing expected
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input vct_pkg::cfg_idx_e idx, input logic [1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == vct_pkg::CFG_SOURCE_SET) src_reg = val;
    else dst_reg = val;
    hold_valid = 1'b0;
  endtask

  task automatic set_sets(input logic [1:0] s, input logic [1:0] d);
    drain();
    write_reg(vct_pkg::CFG_SOURCE_SET, s);
    write_reg(vct_pkg::CFG_TARGET_SET, d);
    cfg_we_i <= 1'b0;
  endtask

  // unit drawn mostly from the vietnamese tables of the given set
  function automatic logic [15:0] pick_unit(input vct_pkg::set_e s);
    int i;
    i = $urandom_range(vct_pkg::ENTRIES - 1);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(255));
      default: begin
        if (s == vct_pkg::SET_TCVN3) return {8'h00, vct_pkg::TCVN_TAB[i]};
        if (s == vct_pkg::SET_VNI) return ($urandom_range(1)) ? vni_base_of(i) : vni_mark_of(i);
        return vct_pkg::UNI_TAB[i];
      end
    endcase
  endfunction

  // directed rows: sets, unit, end of text, typed expectation where obvious
  typedef struct {
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [15:0] unit;
    logic        eot;
    logic        known;
    logic [15:0] want;
  } row_t;

  row_t rows[$];

  task automatic add_row(input logic [1:0] s, input logic [1:0] d, input logic [15:0] u,
                         input logic e, input logic k, input logic [15:0] w);
    row_t r;
    r.src = s; r.dst = d; r.unit = u; r.eot = e; r.known = k; r.want = w;
    rows.push_back(r);
  endtask

  initial begin
    int            n_items;
    int            phase;
    int            len;
    int            i;
    vct_pkg::set_e s;
    beat_t         b;
    row_t          r;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = vct_pkg::CFG_SOURCE_SET;
    cfg_wdata_i      = vct_pkg::SET_UNICODE;
    in_valid_i       = 1'b0;
    in_unit_i        = '0;
    in_end_of_text_i = 1'b0;
    out_stall_i      = 1'b0;
    src_reg          = vct_pkg::SET_UNICODE;
    dst_reg          = vct_pkg::SET_UNICODE;
    hold_unit        = '0;
    hold_valid       = 1'b0;
    mismatches       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_row(vct_pkg::SET_UNICODE, vct_pkg::SET_UNICODE, 16'hFFFF, 1, 1, 16'hFFFF);  // after reset
    add_row(vct_pkg::SET_UNICODE, vct_pkg::SET_UNICODE, 16'h0000, 0, 1, 16'h0000);
    add_row(2'd3, 2'd3, 16'hABCD, 1, 1, 16'hABCD);  // selector three, equal sets
    add_row(vct_pkg::SET_TCVN3, vct_pkg::SET_UNICODE, 16'h00AE, 1, 1, 16'h00C9);  // collision
    add_row(vct_pkg::SET_TCVN3, vct_pkg::SET_UNICODE, 16'h00F0, 0, 1, 16'h1EED);
    add_row(vct_pkg::SET_TCVN3, vct_pkg::SET_UNICODE, 16'h01AE, 0, 1, 16'h01AE);  // above a byte
    add_row(vct_pkg::SET_TCVN3, 2'd3, 16'h00B5, 1, 1, 16'h1EC6);  // target three is unicode
    add_row(vct_pkg::SET_UNICODE, vct_pkg::SET_TCVN3, 16'h0111, 0, 1, 16'h00AE);
    add_row(vct_pkg::SET_UNICODE, vct_pkg::SET_TCVN3, 16'h0041, 1, 1, 16'h0041);  // not in table
    add_row(vct_pkg::SET_UNICODE, vct_pkg::SET_VNI, 16'h00E1, 1, 0, 16'h0000);  // two-unit vni
    add_row(vct_pkg::SET_UNICODE, vct_pkg::SET_VNI, 16'h0110, 0, 0, 16'h0000);
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_UNICODE, 16'h0061, 0, 0, 16'h0000);  // vni hold
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_UNICODE, 16'h00F9, 1, 0, 16'h0000);  // completes pair
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_UNICODE, 16'h0064, 0, 0, 16'h0000);
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_UNICODE, 16'h0078, 0, 0, 16'h0000);  // breaks pair
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_UNICODE, 16'h0079, 1, 0, 16'h0000);  // end flush
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_TCVN3, 16'h0044, 0, 0, 16'h0000);
    add_row(vct_pkg::SET_VNI, vct_pkg::SET_TCVN3, 16'h00D0, 1, 0, 16'h0000);
    add_row(vct_pkg::SET_VNI, 2'd3, 16'h0045, 1, 0, 16'h0000);  // single unit flushed
    add_row(vct_pkg::SET_TCVN3, vct_pkg::SET_VNI, 16'h00B8, 1, 0, 16'h0000);
    add_row(vct_pkg::SET_TCVN3, vct_pkg::SET_VNI, 16'hFFFF, 1, 0, 16'h0000);

    foreach (rows[k]) begin
      r = rows[k];
      if (r.src != src_reg || r.dst != dst_reg) set_sets(r.src, r.dst);
      if (r.known) begin
        // typed expectation for a single-result row
        b.unit = r.want; b.last = 1'b1; b.eot = r.eot;
        exp_beats.push_back(b);
        in_valid_i       <= 1'b1;
        in_unit_i        <= r.unit;
        in_end_of_text_i <= r.eot;
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
      end else begin
        send_unit(r.unit, r.eot);
      end
    end

    // random phases over randomly drawn set pairs and idling mixes
    n_items = 0;
    phase   = 0;
    while (n_items < 1000) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      set_sets(2'($urandom_range(3)), 2'($urandom_range(3)));
      s = set_of(src_reg);
      for (int t = 0; t < 8; t++) begin
        len = $urandom_range(1, 12);
        for (i = 0; i < len; i++) begin
          // well-formed vni pairs dominate when the source is vni
          if (s == vct_pkg::SET_VNI && $urandom_range(3) != 0 && i + 1 < len) begin
            int e;
            e = $urandom_range(vct_pkg::ENTRIES - 1);
            send_unit(vni_base_of(e), 1'b0);
            send_unit(vni_mark_of(e), 1'b0);
            i++;
            n_items += 2;
          end else begin
            send_unit(pick_unit(s), (i == len - 1) || ($urandom_range(15) == 0));
            n_items++;
          end
        end
        // sender waits for all results once per phase
        if (t == 4) begin
          in_valid_i <= 1'b0;
          while (exp_beats.size() != 0) @(posedge clk_i);
        end
      end
      phase++;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== vietnamese_charset_transcoder.f =====
sv/vct_pkg.sv
sv/vct_encoder.sv
sv/vietnamese_charset_transcoder.sv
sv/vct_checker.sv
dv/tb_vietnamese_charset_transcoder.sv
